// File: design/osa_pkg.sv
// ----------------------------------------------------------------------------
// osa_pkg
// Shared constants for the outlier discarding average block: port widths and
// configuration register indexes.
// ----------------------------------------------------------------------------
package osa_pkg;

  // width of the sample and average ports
  localparam int DATA_W = 32;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int DISCARD_W  = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DISCARD_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE   = 2'd1;

endpackage

// File: design/osa_mem.sv
// ----------------------------------------------------------------------------
// osa_mem
// Single-port-write, single-port-read synchronous memory with a registered
// read. Holds one sample and its discard mark per entry.
// ----------------------------------------------------------------------------
module osa_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/osa_div.sv
// ----------------------------------------------------------------------------
// osa_div
// Iterative restoring divider: signed dividend over a positive unsigned
// divisor, quotient truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module osa_div #(
  parameter int DIVIDEND_W = 40,
  parameter int DIVISOR_W  = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic                  run_r;
  logic                  done_r;
  logic [CW-1:0]         cnt_r;
  logic                  neg_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  div_r;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, div_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(DIVIDEND_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[DIVIDEND_W-1];
      quo_r <= dividend[DIVIDEND_W-1] ? -dividend : dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
      rem_r <= fits ? DIVISOR_W'(trial - {1'b0, div_r}) : trial[DIVISOR_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -quo_r : quo_r;

endmodule

// File: design/outlier_discarding_average.sv
// ----------------------------------------------------------------------------
// outlier_discarding_average
// Trimmed mean that drops the samples farthest from the batch mean.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while busy is low and are written to an
// on-chip sample memory; the item with in_last high closes the batch. Busy
// then stays high while the block divides the sum by the count, makes one
// scan of the sample memory per discard (one memory read per cycle), and
// divides the remaining sum. When the discard count is not below the sample
// count, the batch ends at once with an error result.
// The result appears on out_average and out_error for a single cycle marked
// by out_valid and cannot be held off. Configuration writes are taken at any
// time but must only be made while busy is low.
// ----------------------------------------------------------------------------
module outlier_discarding_average
  import osa_pkg::*;
#(
  parameter int MAX_SAMPLES = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [DATA_W-1:0]     in_sample,
  input  logic                  in_last,
  output logic                  out_valid,
  output logic [DATA_W-1:0]     out_average,
  output logic                  out_error,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SB     = SAMPLE_BITS;
  localparam int AW     = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int USUM_W = SB + CNT_W;
  localparam int SUM_W  = SB + CNT_W + 1;
  localparam int VAL_W  = SB + 1;
  localparam int MEM_W  = SB + 1;
  localparam int CMP_W  = (CNT_W > DISCARD_W) ? CNT_W : DISCARD_W;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

  // state codes
  localparam logic [3:0] S_LOAD      = 4'd0;
  localparam logic [3:0] S_CLOSE     = 4'd1;
  localparam logic [3:0] S_MEAN_GO   = 4'd2;
  localparam logic [3:0] S_MEAN_WAIT = 4'd3;
  localparam logic [3:0] S_SCAN      = 4'd4;
  localparam logic [3:0] S_MARK      = 4'd5;
  localparam logic [3:0] S_FIN_GO    = 4'd6;
  localparam logic [3:0] S_FIN_WAIT  = 4'd7;
  localparam logic [3:0] S_OUT       = 4'd8;

  logic [3:0]           state_r;
  logic [DISCARD_W-1:0] dc_cfg_r;
  logic                 mode_cfg_r;
  logic [CNT_W-1:0]     fill_r;
  logic [USUM_W-1:0]    usum_r;
  logic [CNT_W-1:0]     negcnt_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DISCARD_W-1:0] dc_r;
  logic                 mode_r;
  logic [SUM_W-1:0]     sum_r;
  logic [VAL_W-1:0]     mean_r;
  logic [DISCARD_W-1:0] pass_r;
  logic [CNT_W-1:0]     rd_idx_r;
  logic                 rv_r;
  logic [AW-1:0]        ri_r;
  logic                 found_r;
  logic [VAL_W-1:0]     worst_r;
  logic [AW-1:0]        widx_r;
  logic [SB-1:0]        wraw_r;
  logic [SB-1:0]        avg_r;
  logic                 err_r;

  logic                 accept;
  logic                 room;
  logic [CNT_W-1:0]     cnt_nxt;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [MEM_W-1:0]     mem_wdata;
  logic                 mem_re;
  logic [MEM_W-1:0]     mem_rdata;
  logic [VAL_W-1:0]     rd_val;
  logic [VAL_W:0]       diff;
  logic [VAL_W:0]       diff_abs;
  logic [VAL_W-1:0]     delta;
  logic                 take;
  logic [VAL_W-1:0]     wval;
  logic                 div_start;
  logic [CNT_W-1:0]     div_divisor;
  logic                 div_done;
  logic [SUM_W-1:0]     div_q;

  assign busy      = state_r != S_LOAD;
  assign accept    = start && !busy;
  assign room      = fill_r < MAX_CNT;
  assign cnt_nxt   = room ? fill_r + 1'b1 : fill_r;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_cfg_r   <= '0;
      mode_cfg_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DISCARD_COUNT: dc_cfg_r   <= cfg_data[DISCARD_W-1:0];
        REG_SIGNED_MODE:   mode_cfg_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sample memory: samples with a discard mark in the top bit
  assign mem_we    = (accept && room) || (state_r == S_MARK);
  assign mem_waddr = (state_r == S_MARK) ? widx_r : fill_r[AW-1:0];
  assign mem_wdata = (state_r == S_MARK) ? {1'b1, wraw_r} : {1'b0, in_sample[SB-1:0]};
  assign mem_re    = (state_r == S_SCAN) && (rd_idx_r < cnt_r);

  osa_mem #(
    .DEPTH (MAX_SAMPLES),
    .WIDTH (MEM_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  // distance of the read sample from the mean
  assign rd_val   = {mode_r & mem_rdata[SB-1], mem_rdata[SB-1:0]};
  assign diff     = {rd_val[VAL_W-1], rd_val} - {mean_r[VAL_W-1], mean_r};
  assign diff_abs = diff[VAL_W] ? -diff : diff;
  assign delta    = diff_abs[VAL_W-1:0];
  assign take     = rv_r && !mem_rdata[SB] && (!found_r || delta >= worst_r);

  // value of the sample chosen for discard
  assign wval = {mode_r & wraw_r[SB-1], wraw_r};

  // shared divider for the mean and the final average
  assign div_start   = (state_r == S_MEAN_GO) || (state_r == S_FIN_GO);
  assign div_divisor = (state_r == S_FIN_GO) ? cnt_r - CNT_W'(dc_r) : cnt_r;

  osa_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      fill_r   <= '0;
      usum_r   <= '0;
      negcnt_r <= '0;
      rv_r     <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (room) begin
              fill_r   <= fill_r + 1'b1;
              usum_r   <= usum_r + USUM_W'(in_sample[SB-1:0]);
              negcnt_r <= negcnt_r + CNT_W'(in_sample[SB-1]);
            end
            if (in_last) begin
              cnt_r   <= cnt_nxt;
              dc_r    <= dc_cfg_r;
              mode_r  <= mode_cfg_r;
              state_r <= S_CLOSE;
            end
          end
        end
        S_CLOSE: begin
          // too many discards ends the batch at once
          if (CMP_W'(dc_r) >= CMP_W'(cnt_r)) begin
            err_r   <= 1'b1;
            avg_r   <= '0;
            state_r <= S_OUT;
          end else begin
            err_r   <= 1'b0;
            sum_r   <= SUM_W'(usum_r) - (mode_r ? (SUM_W'(negcnt_r) << SB) : '0);
            state_r <= S_MEAN_GO;
          end
        end
        S_MEAN_GO: begin
          state_r <= S_MEAN_WAIT;
        end
        S_MEAN_WAIT: begin
          if (div_done) begin
            mean_r   <= div_q[VAL_W-1:0];
            pass_r   <= '0;
            rd_idx_r <= '0;
            rv_r     <= 1'b0;
            found_r  <= 1'b0;
            state_r  <= (dc_r == '0) ? S_FIN_GO : S_SCAN;
          end
        end
        S_SCAN: begin
          // one read per cycle, compare in the following cycle
          if (mem_re) begin
            rd_idx_r <= rd_idx_r + 1'b1;
            ri_r     <= rd_idx_r[AW-1:0];
          end
          rv_r <= mem_re;
          if (take) begin
            worst_r <= delta;
            widx_r  <= ri_r;
            wraw_r  <= mem_rdata[SB-1:0];
            found_r <= 1'b1;
          end
          if (!mem_re && !rv_r) begin
            state_r <= S_MARK;
          end
        end
        S_MARK: begin
          // mark the farthest sample and take it out of the sum
          sum_r    <= sum_r - {{(SUM_W-VAL_W){wval[VAL_W-1]}}, wval};
          pass_r   <= pass_r + 1'b1;
          rd_idx_r <= '0;
          rv_r     <= 1'b0;
          found_r  <= 1'b0;
          state_r  <= ((pass_r + 1'b1) == dc_r) ? S_FIN_GO : S_SCAN;
        end
        S_FIN_GO: begin
          state_r <= S_FIN_WAIT;
        end
        S_FIN_WAIT: begin
          if (div_done) begin
            avg_r   <= div_q[SB-1:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          fill_r   <= '0;
          usum_r   <= '0;
          negcnt_r <= '0;
          state_r  <= S_LOAD;
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  // result strobe
  assign out_valid   = state_r == S_OUT;
  assign out_average = DATA_W'(avg_r);
  assign out_error   = err_r;

endmodule

// File: design/osa_chk.sv
// ----------------------------------------------------------------------------
// osa_chk
// Port-level checks for the outlier discarding average block, bound to the
// top level.
// ----------------------------------------------------------------------------
module osa_chk
  import osa_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              in_last,
  input logic              out_valid,
  input logic [DATA_W-1:0] out_average,
  input logic              out_error
);

  // a result is a single-cycle strobe
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // an error result carries a zero average
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> (out_average == '0))
    else $error("error result with nonzero average");

  // results only come while the block is busy with a batch
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result outside a batch close");

  // a sample that does not close the batch never stalls the input
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_last) |=> !busy)
    else $error("input stalled after a plain sample");

  // closing the batch starts the processing
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last) |=> busy)
    else $error("batch close did not raise busy");

endmodule

bind outlier_discarding_average osa_chk u_osa_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_last     (in_last),
  .out_valid   (out_valid),
  .out_average (out_average),
  .out_error   (out_error)
);
